[design/strmax_pkg.sv]
// Shared constants for the range-maximum segment tree core.
// Holds field widths, mode codes and parameter defaults; no dependencies.
package strmax_pkg;

  // Default capacity of the element array
  localparam int MaxElementsDef = 1024;

  // Payload field widths
  localparam int ValueW = 32;
  localparam int IndexW = 10;
  localparam int CountW = 11;
  localparam int ModeW  = 2;

  // Stream and register port widths
  localparam int InDataW  = 64;
  localparam int OutDataW = 32;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;

  // Item modes carried in the input tuser
  localparam logic [ModeW-1:0] ModeLoad  = 2'd0;
  localparam logic [ModeW-1:0] ModeBuild = 2'd1;
  localparam logic [ModeW-1:0] ModeQuery = 2'd2;

  // Register indexes
  localparam logic RegElementCount = 1'b0;

  // Most negative value: neutral element of the maximum
  localparam logic [ValueW-1:0] ValueMin = {1'b1, {(ValueW-1){1'b0}}};

endpackage

[design/segment_tree_range_max_core.sv]
// Top level of the range-maximum segment tree core.
// Depends on strmax_pkg and the strmax_ram node memory.
//
// Usage: input beats arrive on s_axis; tuser carries the mode (load, build,
// query), tdata the index, value and range fields. Each beat yields exactly
// one result beat on m_axis: tdata holds the range maximum (0 for load and
// build, -1 for an invalid query), tuser the invalid flag.
// The element count register sits at APB address 0; the user must write it
// only while the core is idle, as the core itself does not enforce this.
// One item is worked at a time; s_axis_tready is low until the result is
// in the output register. All node reads go through the single read port of
// the node memory and all value compares through one signed comparator.
// A valid query makes at most two memory reads per tree level; a build
// visits every internal node from SPAN-1 down to the root, reading the left
// child, reading the right child, then writing the parent (SPAN =
// MAX_ELEMENTS rounded up to a power of two).
// The next item is taken as soon as the result is registered, even while
// the receiver stalls m_axis; a further result then waits inside the core.
// Reset sets the element count to 1 and clears all handshake state; the
// node memory holds nothing defined until loaded and built.
module segment_tree_range_max_core #(
  parameter int MAX_ELEMENTS = strmax_pkg::MaxElementsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata fields from bit 0: element_index[9:0], element_value[41:10],
  // range_start[51:42], range_end[61:52], zero fill [63:62]
  input  logic [strmax_pkg::InDataW-1:0] s_axis_tdata,
  // tuser fields from bit 0: mode[1:0]
  input  logic [strmax_pkg::ModeW-1:0]   s_axis_tuser,
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata fields from bit 0: range_maximum[31:0]
  output logic [strmax_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser fields from bit 0: query_invalid[0]
  output logic                           m_axis_tuser,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [strmax_pkg::ApbAddrW-1:0] paddr,
  input  logic [strmax_pkg::ApbDataW-1:0] pwdata,
  output logic [strmax_pkg::ApbDataW-1:0] prdata,
  output logic                           pready
);

  import strmax_pkg::*;

  localparam int Span    = 1 << $clog2(MAX_ELEMENTS);
  localparam int Levels  = $clog2(Span);
  localparam int NodeAw  = Levels + 1;
  localparam int RangeW  = NodeAw + 1;
  localparam int KW      = (Levels > 0) ? Levels : 1;

  // Sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StBrdL  = 3'd1;
  localparam logic [2:0] StBrdR  = 3'd2;
  localparam logic [2:0] StBwr   = 3'd3;
  localparam logic [2:0] StQlo   = 3'd4;
  localparam logic [2:0] StQhi   = 3'd5;
  localparam logic [2:0] StFin   = 3'd6;

  // Input field unpacking
  logic [ModeW-1:0]  in_mode;
  logic [IndexW-1:0] in_index;
  logic [ValueW-1:0] in_value;
  logic [IndexW-1:0] in_start;
  logic [IndexW-1:0] in_end;

  assign in_mode  = s_axis_tuser;
  assign in_index = s_axis_tdata[9:0];
  assign in_value = s_axis_tdata[41:10];
  assign in_start = s_axis_tdata[51:42];
  assign in_end   = s_axis_tdata[61:52];

  logic [2:0]        state_q, state_d;
  logic [CountW-1:0] count_q;
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_data_q;
  logic              out_inv_q;
  logic [ValueW-1:0] res_q, res_d;
  logic              inv_q, inv_d;
  logic [ValueW-1:0] best_q, best_d;
  logic              pend_q, pend_d;
  logic [RangeW-1:0] lo_q, lo_d;
  logic [RangeW-1:0] hi_q, hi_d;
  logic [KW-1:0]     k_q, k_d;

  logic              in_beat;
  logic              out_free;
  logic              cfg_write;
  logic              query_bad;
  logic              load_ok;

  // Memory port signals
  logic              mem_wr_en;
  logic [NodeAw-1:0] mem_wr_addr;
  logic [ValueW-1:0] mem_wr_data;
  logic [NodeAw-1:0] mem_rd_addr;
  logic [ValueW-1:0] mem_rd_data;

  // Shared comparator: larger of best_q and the read word
  logic [ValueW-1:0] cmp_max;
  logic [ValueW-1:0] fold;

  assign cmp_max = ($signed(mem_rd_data) > $signed(best_q)) ? mem_rd_data : best_q;
  assign fold    = pend_q ? cmp_max : best_q;

  assign s_axis_tready = (state_q == StIdle);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Range check against range order, the element count and the array capacity
  assign query_bad = (in_start > in_end)
                  || (32'(in_end) >= 32'(count_q))
                  || (32'(in_end) >= MAX_ELEMENTS);
  assign load_ok   = (32'(in_index) < MAX_ELEMENTS);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    inv_d       = inv_q;
    best_d      = best_q;
    pend_d      = 1'b0;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    mem_wr_en   = 1'b0;
    mem_wr_addr = NodeAw'(Span) + NodeAw'(in_index);
    mem_wr_data = in_value;
    mem_rd_addr = NodeAw'(lo_q);

    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          res_d   = '0;
          inv_d   = 1'b0;
          state_d = StFin;
          case (in_mode)
            ModeLoad: begin
              mem_wr_en = load_ok;
            end
            ModeBuild: begin
              k_d     = KW'(Span - 1);
              state_d = StBrdL;
            end
            ModeQuery: begin
              if (query_bad) begin
                res_d = '1;
                inv_d = 1'b1;
              end else begin
                lo_d    = RangeW'(Span) + RangeW'(in_start);
                hi_d    = RangeW'(Span) + RangeW'(in_end) + RangeW'(1);
                best_d  = ValueMin;
                state_d = StQlo;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StBrdL: begin
        mem_rd_addr = {k_q, 1'b0};
        state_d     = StBrdR;
      end
      StBrdR: begin
        // Left child arrives; fetch the right child
        mem_rd_addr = {k_q, 1'b1};
        best_d      = mem_rd_data;
        state_d     = StBwr;
      end
      StBwr: begin
        // Store the larger child into the parent
        mem_wr_en   = 1'b1;
        mem_wr_addr = NodeAw'(k_q);
        mem_wr_data = cmp_max;
        if (k_q == KW'(1)) begin
          state_d = StFin;
        end else begin
          k_d     = k_q - KW'(1);
          state_d = StBrdL;
        end
      end
      StQlo: begin
        best_d = fold;
        if (lo_q < hi_q) begin
          if (lo_q[0]) begin
            mem_rd_addr = NodeAw'(lo_q);
            lo_d        = lo_q + RangeW'(1);
            pend_d      = 1'b1;
          end
          state_d = StQhi;
        end else begin
          res_d   = fold;
          state_d = StFin;
        end
      end
      StQhi: begin
        best_d = fold;
        if (hi_q[0]) begin
          mem_rd_addr = NodeAw'(hi_q - RangeW'(1));
          pend_d      = 1'b1;
        end
        // An odd hi drops to the same parent as hi - 1
        lo_d    = lo_q >> 1;
        hi_d    = hi_q >> 1;
        state_d = StQlo;
      end
      StFin: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      count_q     <= CountW'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      if (cfg_write) begin
        count_q <= pwdata[CountW-1:0];
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    inv_q  <= inv_d;
    best_q <= best_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    k_q    <= k_d;
    if ((state_q == StFin) && out_free) begin
      out_data_q <= res_q;
      out_inv_q  <= inv_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_inv_q;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == RegElementCount);
  assign prdata    = (paddr[2] == RegElementCount) ? ApbDataW'(count_q) : '0;

  // Node memory: root at 1, leaves from Span upward
  strmax_ram #(
    .Width (ValueW),
    .Depth (2 * Span)
  ) u_nodes (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

endmodule

[design/strmax_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; width and depth come from parameters.
module strmax_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write one word, read one word every cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
